// ===== sv/tfn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the triangle face normal pipeline: widths, register indexes and payload types.
package tfn_pkg;

  localparam int COORD_BITS = 24;
  localparam int SCALE_BITS = 16;
  localparam int SCALE_FRAC = 12;
  localparam int NORMAL_BITS = 16;
  localparam int NORM_BITS = 30;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Z = 2'd2;

  localparam logic [SCALE_BITS-1:0] SCALE_ONE = 16'd4096;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] first_z;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic signed [COORD_BITS-1:0] second_z;
    logic signed [COORD_BITS-1:0] third_x;
    logic signed [COORD_BITS-1:0] third_y;
    logic signed [COORD_BITS-1:0] third_z;
  } tri_in_t;

  typedef struct packed {
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic                          degenerate;
  } tri_out_t;

endpackage

// ===== sv/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// Triangle face normal: per-axis scaling, edge cross product and normalisation to Q1.15.
// One triangle is accepted every cycle; the whole pipeline holds while a result is refused.
// The square root takes 31 stages and the division 16 stages, which set the latency.
// Reset clears every valid bit and sets all three scale registers to 1.0.
// Configuration writes are always accepted; a new scale applies once its register is written.
module triangle_face_normal import tfn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  tri_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tri_out_t                out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SCALE_BITS-1:0]   cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int PW1 = CW + SCALE_BITS + 1;
  localparam int EDGE_SHIFT = (CW > 31) ? (CW - 31) : 0;
  localparam int DW = CW + 1;
  localparam int EW = DW - EDGE_SHIFT;
  localparam int XW = 2 * EW;
  localparam int CRW = XW + 1;
  localparam int MW = CRW - 1;
  localparam int SHW = $clog2(MW + 1);
  localparam int L2W = 2 * NORM_BITS + 2;
  localparam int LW = NORM_BITS + 1;
  localparam int SQS = NORM_BITS + 1;
  localparam int FRAC = NORMAL_BITS - 1;
  localparam int QW = NORMAL_BITS;
  localparam int NW = LW + FRAC;
  localparam logic signed [PW1-1:0] CMAX = {{(PW1-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [PW1-1:0] CMIN = ~CMAX;
  localparam logic signed [PW1-1:0] HALF = PW1'(1) << (SCALE_FRAC - 1);
  localparam logic [QW-1:0] NMAX = {1'b0, {(QW-1){1'b1}}};

  function automatic logic [SHW-1:0] bit_len(input logic [MW-1:0] x);
    logic [SHW-1:0] n;
    n = '0;
    for (int i = 0; i < MW; i++) begin
      if (x[i]) n = SHW'(i + 1);
    end
    return n;
  endfunction

  logic en;
  logic [SCALE_BITS-1:0] scale_x_r, scale_y_r, scale_z_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic signed [PW1-1:0] p_r [9];
  logic signed [PW1-1:0] p_nxt [9];
  logic signed [CW-1:0]  s_r [9];
  logic signed [CW-1:0]  s_nxt [9];
  logic signed [EW-1:0]  a_r [3];
  logic signed [EW-1:0]  b_r [3];
  logic signed [EW-1:0]  a_nxt [3];
  logic signed [EW-1:0]  b_nxt [3];
  logic signed [XW-1:0]  x_r [6];
  logic signed [CRW-1:0] c_r [3];
  logic [2:0][MW-1:0]    m6_r, m7_r;
  logic [2:0]            neg6_r, neg7_r, neg8_r, neg9_r;
  logic                  dg6_r, dg7_r, dg8_r, dg9_r;
  logic [SHW-1:0]        sh_r, sh_nxt;
  logic [2:0][NORM_BITS-1:0]   r8_r, r9_r;
  logic [2:0][2*NORM_BITS-1:0] q9_r;

  logic [L2W-1:0]              sq_x_r   [SQS+1];
  logic [L2W-1:0]              sq_res_r [SQS+1];
  logic [2:0][NORM_BITS-1:0]   sq_rv_r  [SQS+1];
  logic [2:0]                  sq_neg_r [SQS+1];
  logic                        sq_dg_r  [SQS+1];
  logic                        sq_v_r   [SQS+1];

  logic [NW-1:0]               dv_len_r [QW+1];
  logic [2:0][NW-1:0]          dv_num_r [QW+1];
  logic [2:0][QW-1:0]          dv_q_r   [QW+1];
  logic [2:0]                  dv_neg_r [QW+1];
  logic                        dv_dg_r  [QW+1];
  logic                        dv_v_r   [QW+1];

  logic [LW-1:0]  len;
  tri_out_t       out_r, out_nxt;
  logic           out_valid_r;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= SCALE_ONE;
      scale_y_r <= SCALE_ONE;
      scale_z_r <= SCALE_ONE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCALE_X: scale_x_r <= cfg_data;
        CFG_SCALE_Y: scale_y_r <= cfg_data;
        CFG_SCALE_Z: scale_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [CW-1:0] crd [9];
    logic [SCALE_BITS-1:0] scl [3];
    crd[0] = in_data.first_x;  crd[1] = in_data.first_y;  crd[2] = in_data.first_z;
    crd[3] = in_data.second_x; crd[4] = in_data.second_y; crd[5] = in_data.second_z;
    crd[6] = in_data.third_x;  crd[7] = in_data.third_y;  crd[8] = in_data.third_z;
    scl[0] = scale_x_r;
    scl[1] = scale_y_r;
    scl[2] = scale_z_r;
    for (int i = 0; i < 9; i++) begin
      p_nxt[i] = crd[i] * $signed({1'b0, scl[i % 3]});
    end
  end

  always_comb begin
    logic signed [PW1-1:0] rnd;
    for (int i = 0; i < 9; i++) begin
      rnd = (p_r[i] + HALF) >>> SCALE_FRAC;
      if (rnd > CMAX) begin
        s_nxt[i] = CMAX[CW-1:0];
      end else if (rnd < CMIN) begin
        s_nxt[i] = CMIN[CW-1:0];
      end else begin
        s_nxt[i] = rnd[CW-1:0];
      end
    end
  end

  always_comb begin
    logic signed [DW-1:0] da, db;
    for (int i = 0; i < 3; i++) begin
      da = DW'(s_r[i]) - DW'(s_r[i+3]);
      db = DW'(s_r[i+3]) - DW'(s_r[i+6]);
      a_nxt[i] = EW'(da >>> EDGE_SHIFT);
      b_nxt[i] = EW'(db >>> EDGE_SHIFT);
    end
  end

  assign sh_nxt = (bit_len(m6_r[0] | m6_r[1] | m6_r[2]) > SHW'(NORM_BITS)) ?
                  bit_len(m6_r[0] | m6_r[1] | m6_r[2]) - SHW'(NORM_BITS) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
      s_r <= s_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      x_r[0] <= a_r[1] * b_r[2];
      x_r[1] <= a_r[2] * b_r[1];
      x_r[2] <= a_r[2] * b_r[0];
      x_r[3] <= a_r[0] * b_r[2];
      x_r[4] <= a_r[0] * b_r[1];
      x_r[5] <= a_r[1] * b_r[0];
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= CRW'(x_r[2*i]) - CRW'(x_r[2*i+1]);
        m6_r[i] <= c_r[i][CRW-1] ? MW'(-c_r[i]) : MW'(c_r[i]);
        neg6_r[i] <= c_r[i][CRW-1];
        r8_r[i] <= NORM_BITS'(m7_r[i] >> sh_r);
        q9_r[i] <= r8_r[i] * r8_r[i];
      end
      dg6_r <= (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
      m7_r <= m6_r;
      neg7_r <= neg6_r;
      dg7_r <= dg6_r;
      sh_r <= sh_nxt;
      neg8_r <= neg7_r;
      dg8_r <= dg7_r;
      r9_r <= r8_r;
      neg9_r <= neg8_r;
      dg9_r <= dg8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (en) begin
      sq_v_r[0] <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0] <= L2W'(q9_r[0]) + L2W'(q9_r[1]) + L2W'(q9_r[2]);
      sq_res_r[0] <= '0;
      sq_rv_r[0] <= r9_r;
      sq_neg_r[0] <= neg9_r;
      sq_dg_r[0] <= dg9_r;
    end
  end

  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    localparam logic [L2W-1:0] BIT = L2W'(1) << (2 * (SQS - 1 - j));
    logic [L2W-1:0] trial;
    assign trial = sq_res_r[j] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_x_r[j] >= trial) begin
          sq_x_r[j+1] <= sq_x_r[j] - trial;
          sq_res_r[j+1] <= (sq_res_r[j] >> 1) + BIT;
        end else begin
          sq_x_r[j+1] <= sq_x_r[j];
          sq_res_r[j+1] <= sq_res_r[j] >> 1;
        end
        sq_rv_r[j+1] <= sq_rv_r[j];
        sq_neg_r[j+1] <= sq_neg_r[j];
        sq_dg_r[j+1] <= sq_dg_r[j];
      end
    end
  end

  assign len = (sq_res_r[SQS][LW-1:0] == '0) ? LW'(1) : sq_res_r[SQS][LW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= sq_v_r[SQS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_len_r[0] <= NW'(len);
      for (int i = 0; i < 3; i++) begin
        dv_num_r[0][i] <= (NW'(sq_rv_r[SQS][i]) << FRAC) + NW'(len >> 1);
      end
      dv_q_r[0] <= '0;
      dv_neg_r[0] <= sq_neg_r[SQS];
      dv_dg_r[0] <= sq_dg_r[SQS];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [NW-1:0] dsub;
    assign dsub = dv_len_r[j] << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_num_r[j][i] >= dsub) begin
            dv_num_r[j+1][i] <= dv_num_r[j][i] - dsub;
            dv_q_r[j+1][i] <= dv_q_r[j][i] | (QW'(1) << K);
          end else begin
            dv_num_r[j+1][i] <= dv_num_r[j][i];
            dv_q_r[j+1][i] <= dv_q_r[j][i];
          end
        end
        dv_len_r[j+1] <= dv_len_r[j];
        dv_neg_r[j+1] <= dv_neg_r[j];
        dv_dg_r[j+1] <= dv_dg_r[j];
      end
    end
  end

  always_comb begin
    logic [QW-1:0] n [3];
    logic [QW-1:0] o [3];
    for (int i = 0; i < 3; i++) begin
      n[i] = (dv_q_r[QW][i] > NMAX) ? NMAX : dv_q_r[QW][i];
      if (dv_dg_r[QW]) begin
        o[i] = '0;
      end else if (dv_neg_r[QW][i]) begin
        o[i] = -n[i];
      end else begin
        o[i] = n[i];
      end
    end
    out_nxt.normal_x = o[0];
    out_nxt.normal_y = o[1];
    out_nxt.normal_z = o[2];
    out_nxt.degenerate = dv_dg_r[QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== sv/tfn_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the triangle face normal block, with its bind statement.
module tfn_checker import tfn_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input tri_out_t                out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate result with non-zero normal");

  a_nomin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.normal_x != 16'sh8000 && out_data.normal_y != 16'sh8000 &&
                  out_data.normal_z != 16'sh8000)
    else $error("normal component at negative full scale");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("pipeline stall does not follow the result channel");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_face_normal tfn_checker u_tfn_checker (.*);
